@@ sv/efs_pkg.sv @@
package efs_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COLOR_BITS_DEF = 32;

    // op field codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

endpackage

@@ sv/efs_mul.sv @@
module efs_mul
    import efs_pkg::*;
#(
    parameter int A_W = 2 * COORD_BITS_DEF - 2,
    parameter int B_W = COORD_BITS_DEF + 2
)
(
    input  logic                     clk,
    input  logic [A_W-1:0]           op_a,
    input  logic signed [B_W-1:0]    op_b,
    output logic signed [A_W+B_W:0]  prod
);

    logic signed [A_W+B_W:0] prod_reg;
    logic signed [A_W+B_W:0] prod_next;

    // op_a is unsigned, op_b two's complement
    assign prod_next = $signed({1'b0, op_a}) * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ sv/efs_out.sv @@
module efs_out
    import efs_pkg::*;
#(
    parameter int OUT_W   = COORD_BITS_DEF + 1,
    parameter int COLOR_W = COLOR_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [OUT_W-1:0]         left_in,
    input  logic [OUT_W-1:0]         right_in,
    input  logic [OUT_W-1:0]         row_in,
    input  logic [COLOR_W-1:0]       color_in,
    input  logic                     last_in,
    output logic                     free,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  span_left,
    output logic signed [OUT_W-1:0]  span_right,
    output logic signed [OUT_W-1:0]  span_row,
    output logic [COLOR_W-1:0]       span_color,
    output logic                     last_span
);

    logic               valid_reg;
    logic               valid_next;
    logic [OUT_W-1:0]   left_reg;
    logic [OUT_W-1:0]   right_reg;
    logic [OUT_W-1:0]   row_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               last_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg  <= left_in;
            right_reg <= right_in;
            row_reg   <= row_in;
            color_reg <= color_in;
            last_reg  <= last_in;
        end
    end

    assign out_valid  = valid_reg;
    assign span_left  = $signed(left_reg);
    assign span_right = $signed(right_reg);
    assign span_row   = $signed(row_reg);
    assign span_color = color_reg;
    assign last_span  = last_reg;

endmodule

@@ sv/filled_ellipse_span_generator.sv @@
// Filled ellipse span generator.
// Input channel (in_valid/in_ready): op = OP_LOAD stores center, radii and
// color; op = OP_STEP walks one row pair, from y = b down to y = 0, and
// yields two spans (rows cy-y and cy+y, columns cx-x+1 .. cx+x-1).
// Output channel (out_valid/out_ready): one span per transfer; last_span
// marks the second span of row 0. A load with a radius <= 0 gives an empty
// ellipse; a step with no ellipse loaded is taken and dropped.
// One shared multiplier (with registered product) does all products under
// a small sequencer; in_ready is high only while the sequencer is idle.
// Load: states ST_L_AA, ST_L_BB, ST_L_ERR and ST_L_FIN run before ready
// again, forming a*a, b*b and b*b*a. Step: each x increment on that row
// pair costs one multiply state (ST_CHK) and one accumulate state (ST_ADDX).
// The first span is registered from ST_OUT0, after the last ST_CHK and ST_ADDY.
// A stalled receiver holds the output register; the sequencer waits in
// its emit states until the register frees, and a new input is taken as
// soon as the second span is in the register.
// Reset clears the sequencer, the output valid and the loaded ellipse.
module filled_ellipse_span_generator
    import efs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COLOR_BITS = COLOR_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic signed [COORD_BITS-1:0]  center_x,
    input  logic signed [COORD_BITS-1:0]  center_y,
    input  logic signed [COORD_BITS-1:0]  radius_x,
    input  logic signed [COORD_BITS-1:0]  radius_y,
    input  logic [COLOR_BITS-1:0]         fill_color,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS:0]    span_left,
    output logic signed [COORD_BITS:0]    span_right,
    output logic signed [COORD_BITS:0]    span_row,
    output logic [COLOR_BITS-1:0]         span_color,
    output logic                          last_span
);

    localparam int C      = COORD_BITS;
    localparam int OUT_W  = C + 1;
    localparam int SQ_W   = 2 * C - 2;
    localparam int OPB_W  = C + 2;
    localparam int PROD_W = SQ_W + OPB_W + 1;
    localparam int ERR_W  = PROD_W + 1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_L_AA  = 10'b00_0000_0010,
        ST_L_BB  = 10'b00_0000_0100,
        ST_L_ERR = 10'b00_0000_1000,
        ST_L_FIN = 10'b00_0001_0000,
        ST_CHK   = 10'b00_0010_0000,
        ST_ADDX  = 10'b00_0100_0000,
        ST_ADDY  = 10'b00_1000_0000,
        ST_OUT0  = 10'b01_0000_0000,
        ST_OUT1  = 10'b10_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [C-1:0]             ccol_reg, ccol_next;
    logic [C-1:0]             crow_reg, crow_next;
    logic [C-1:0]             ra_reg, ra_next;
    logic [SQ_W-1:0]          asq_reg, asq_next;
    logic [SQ_W-1:0]          bsq_reg, bsq_next;
    logic [C-1:0]             x_reg, x_next;
    logic [C-1:0]             y_reg, y_next;
    logic [ERR_W-1:0]         err_reg, err_next;
    logic [COLOR_BITS-1:0]    color_reg, color_next;
    logic                     active_reg, active_next;

    logic [SQ_W-1:0]          mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [ERR_W-1:0]         prod_ext;

    logic                     in_xfer;
    logic                     a_pos;
    logic                     b_pos;
    logic                     out_free;
    logic                     out_load;
    logic [OUT_W-1:0]         cc_ext;
    logic [OUT_W-1:0]         cr_ext;
    logic [OUT_W-1:0]         left_w;
    logic [OUT_W-1:0]         right_w;
    logic [OUT_W-1:0]         row_w;
    logic                     last_w;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign a_pos    = !radius_x[C-1] && (radius_x != '0);
    assign b_pos    = !radius_y[C-1] && (radius_y != '0);
    assign prod_ext = ERR_W'(prod);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = asq_reg;
        mul_b = '0;
        case (state_reg)
            ST_L_AA:
            begin
                mul_a = SQ_W'(ra_reg);
                mul_b = $signed(OPB_W'(ra_reg));
            end
            ST_L_BB:
            begin
                mul_a = SQ_W'(y_reg);
                mul_b = $signed(OPB_W'(y_reg));
            end
            ST_L_ERR:
            begin
                mul_a = prod[SQ_W-1:0];
                mul_b = $signed(OPB_W'(ra_reg));
            end
            ST_CHK:
            begin
                if (err_reg[ERR_W-1])
                begin
                    mul_a = bsq_reg;
                    mul_b = $signed({1'b0, x_reg, 1'b1});
                end
                else
                begin
                    mul_a = asq_reg;
                    mul_b = $signed(OPB_W'(1) - {1'b0, y_reg, 1'b0});
                end
            end
            default:
            begin
                mul_a = asq_reg;
                mul_b = '0;
            end
        endcase
    end

    efs_mul #(
        .A_W (SQ_W),
        .B_W (OPB_W)
    ) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // span arithmetic, wraps to OUT_W bits
    assign cc_ext  = {ccol_reg[C-1], ccol_reg};
    assign cr_ext  = {crow_reg[C-1], crow_reg};
    assign left_w  = cc_ext - {1'b0, x_reg} + OUT_W'(1);
    assign right_w = cc_ext + {1'b0, x_reg} - OUT_W'(1);
    assign row_w   = (state_reg == ST_OUT0) ? (cr_ext - {1'b0, y_reg})
                                            : (cr_ext + {1'b0, y_reg});
    assign last_w  = (state_reg == ST_OUT1) && (y_reg == '0);
    assign out_load = ((state_reg == ST_OUT0) || (state_reg == ST_OUT1)) && out_free;

    always_comb
    begin
        state_next  = state_reg;
        ccol_next   = ccol_reg;
        crow_next   = crow_reg;
        ra_next     = ra_reg;
        asq_next    = asq_reg;
        bsq_next    = bsq_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        err_next    = err_reg;
        color_next  = color_reg;
        active_next = active_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (op == OP_LOAD)
                    begin
                        ccol_next   = center_x;
                        crow_next   = center_y;
                        color_next  = fill_color;
                        ra_next     = radius_x;
                        active_next = 1'b0;
                        x_next      = '0;
                        if (a_pos && b_pos)
                        begin
                            y_next     = radius_y;
                            state_next = ST_L_AA;
                        end
                        else
                        begin
                            asq_next = '0;
                            bsq_next = '0;
                            y_next   = '0;
                            err_next = '0;
                        end
                    end
                    else if (active_reg)
                    begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_L_AA:
            begin
                state_next = ST_L_BB;
            end
            ST_L_BB:
            begin
                asq_next   = prod[SQ_W-1:0];
                state_next = ST_L_ERR;
            end
            ST_L_ERR:
            begin
                bsq_next   = prod[SQ_W-1:0];
                state_next = ST_L_FIN;
            end
            ST_L_FIN:
            begin
                err_next    = '0 - prod_ext;
                active_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_CHK:
            begin
                state_next = err_reg[ERR_W-1] ? ST_ADDX : ST_ADDY;
            end
            ST_ADDX:
            begin
                err_next   = err_reg + prod_ext;
                x_next     = x_reg + C'(1);
                state_next = ST_CHK;
            end
            ST_ADDY:
            begin
                err_next   = err_reg + prod_ext;
                state_next = ST_OUT0;
            end
            ST_OUT0:
            begin
                if (out_free)
                begin
                    state_next = ST_OUT1;
                end
            end
            ST_OUT1:
            begin
                if (out_free)
                begin
                    if (y_reg == '0)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        y_next = y_reg - C'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            ccol_reg   <= '0;
            crow_reg   <= '0;
            ra_reg     <= '0;
            asq_reg    <= '0;
            bsq_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            err_reg    <= '0;
            color_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            ccol_reg   <= ccol_next;
            crow_reg   <= crow_next;
            ra_reg     <= ra_next;
            asq_reg    <= asq_next;
            bsq_reg    <= bsq_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            err_reg    <= err_next;
            color_reg  <= color_next;
        end
    end

    efs_out #(
        .OUT_W   (OUT_W),
        .COLOR_W (COLOR_BITS)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .left_in    (left_w),
        .right_in   (right_w),
        .row_in     (row_w),
        .color_in   (color_reg),
        .last_in    (last_w),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .span_left  (span_left),
        .span_right (span_right),
        .span_row   (span_row),
        .span_color (span_color),
        .last_span  (last_span)
    );

endmodule
